// ----- sv/ifs_pkg.sv -----
// Shared constants, register and sequencer codes for the impedance filter step block.
package ifs_pkg;

    localparam int AXES           = 3;
    localparam int DATA_WIDTH_DEF = 32;

    // Coefficient and time step formats
    localparam int COEF_BITS     = 20;
    localparam int COEF_REG_BITS = 60;
    localparam int DT_BITS       = 24;
    localparam logic [DT_BITS-1:0] DT_RESET = 24'd16777;

    // Fixed-point alignment
    localparam int POS_SHIFT = 24;
    localparam int ACC_SPLIT = 32;
    localparam int KD_SHIFT  = 4;
    localparam int VEL_SHIFT = 4;

    // Configuration port
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_IDX_LSB   = 3;

    typedef enum logic [1:0] {
        REG_STIFF,
        REG_DAMP,
        REG_IMASS,
        REG_DT
    } ifs_reg_t;

    typedef enum logic [3:0] {
        ST_POS_MUL,
        ST_K_MUL,
        ST_D_MUL,
        ST_F_MUL,
        ST_ACC,
        ST_LO_MUL,
        ST_HI_MUL,
        ST_T_SUM,
        ST_DONE
    } ifs_step_t;

    // Cycles from acceptance up to and including the final step
    localparam int BUSY_CYCLES = 9;

    typedef struct packed {
        logic      load;
        logic      run;
        ifs_step_t step;
    } ifs_ctl_t;

endpackage

// ----- sv/impedance_filter_step.sv -----
// Top level: configuration registers, step sequencer, three axis lanes and merge stage.
//
//  channel | handshake              | beat contents
//  --------+------------------------+------------------------------------------------
//  config  | psel/penable/pready    | paddr, pwdata (64 bit), prdata
//  input   | in_valid / in_stall    | meas_pos, goal_pos, goal_vel, force per axis
//  output  | out_valid / out_stall  | cmd_pos, cmd_vel per axis
//
//  An input beat occupies the sequencer from ST_POS_MUL to ST_DONE; the result is loaded
//  into the output register as the sequencer leaves ST_DONE, so a new beat is taken only
//  once the last is through. The steps come from the six products each lane runs
//  in turn through its one multiplier, plus the sums between them.
//  Reset clears the velocity state to zero and loads the default time step; no sweep.
//  When the output register is full and stalled, the sequencer holds on its last step.
module impedance_filter_step #(
    parameter int DATA_WIDTH = ifs_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ifs_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [ifs_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [ifs_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [DATA_WIDTH-1:0]        meas_pos_x,
    input  logic signed [DATA_WIDTH-1:0]        meas_pos_y,
    input  logic signed [DATA_WIDTH-1:0]        meas_pos_z,
    input  logic signed [DATA_WIDTH-1:0]        goal_pos_x,
    input  logic signed [DATA_WIDTH-1:0]        goal_pos_y,
    input  logic signed [DATA_WIDTH-1:0]        goal_pos_z,
    input  logic signed [DATA_WIDTH-1:0]        goal_vel_x,
    input  logic signed [DATA_WIDTH-1:0]        goal_vel_y,
    input  logic signed [DATA_WIDTH-1:0]        goal_vel_z,
    input  logic signed [DATA_WIDTH-1:0]        force_x,
    input  logic signed [DATA_WIDTH-1:0]        force_y,
    input  logic signed [DATA_WIDTH-1:0]        force_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [DATA_WIDTH-1:0]        cmd_pos_x,
    output logic signed [DATA_WIDTH-1:0]        cmd_pos_y,
    output logic signed [DATA_WIDTH-1:0]        cmd_pos_z,
    output logic signed [DATA_WIDTH-1:0]        cmd_vel_x,
    output logic signed [DATA_WIDTH-1:0]        cmd_vel_y,
    output logic signed [DATA_WIDTH-1:0]        cmd_vel_z
);
    import ifs_pkg::*;

    logic [COEF_REG_BITS-1:0] stiff_reg;
    logic [COEF_REG_BITS-1:0] damp_reg;
    logic [COEF_REG_BITS-1:0] imass_reg;
    logic [DT_BITS-1:0]       dt_reg;

    logic      busy_reg;
    logic      busy_next;
    ifs_step_t step_reg;
    ifs_step_t step_next;

    logic      in_accept;
    logic      cfg_write;
    logic      merge_ready;
    logic      fire;
    ifs_reg_t  cfg_idx;
    ifs_ctl_t  ctl;

    logic signed [DATA_WIDTH-1:0] meas_arr  [AXES];
    logic signed [DATA_WIDTH-1:0] goal_arr  [AXES];
    logic signed [DATA_WIDTH-1:0] gvel_arr  [AXES];
    logic signed [DATA_WIDTH-1:0] frc_arr   [AXES];
    logic signed [DATA_WIDTH-1:0] lane_pos  [AXES];
    logic signed [DATA_WIDTH-1:0] lane_vel  [AXES];
    logic signed [DATA_WIDTH-1:0] cmd_pos   [AXES];
    logic signed [DATA_WIDTH-1:0] cmd_vel   [AXES];
    logic signed [DATA_WIDTH-1:0] vel_state [AXES];

    assign meas_arr[0] = meas_pos_x;
    assign meas_arr[1] = meas_pos_y;
    assign meas_arr[2] = meas_pos_z;
    assign goal_arr[0] = goal_pos_x;
    assign goal_arr[1] = goal_pos_y;
    assign goal_arr[2] = goal_pos_z;
    assign gvel_arr[0] = goal_vel_x;
    assign gvel_arr[1] = goal_vel_y;
    assign gvel_arr[2] = goal_vel_z;
    assign frc_arr[0]  = force_x;
    assign frc_arr[1]  = force_y;
    assign frc_arr[2]  = force_z;

    assign cmd_pos_x = cmd_pos[0];
    assign cmd_pos_y = cmd_pos[1];
    assign cmd_pos_z = cmd_pos[2];
    assign cmd_vel_x = cmd_vel[0];
    assign cmd_vel_y = cmd_vel[1];
    assign cmd_vel_z = cmd_vel[2];

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = ifs_reg_t'(paddr[CFG_ADDR_BITS-1:CFG_IDX_LSB]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_STIFF: prdata = CFG_DATA_BITS'(stiff_reg);
            REG_DAMP:  prdata = CFG_DATA_BITS'(damp_reg);
            REG_IMASS: prdata = CFG_DATA_BITS'(imass_reg);
            REG_DT:    prdata = CFG_DATA_BITS'(dt_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= '0;
            damp_reg  <= '0;
            imass_reg <= '0;
            dt_reg    <= DT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_STIFF: stiff_reg <= pwdata[COEF_REG_BITS-1:0];
                REG_DAMP:  damp_reg  <= pwdata[COEF_REG_BITS-1:0];
                REG_IMASS: imass_reg <= pwdata[COEF_REG_BITS-1:0];
                REG_DT:    dt_reg    <= pwdata[DT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Step sequencer
    assign in_stall  = busy_reg;
    assign in_accept = in_valid && !busy_reg;
    assign fire      = busy_reg && (step_reg == ST_DONE) && merge_ready;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (in_accept)
        begin
            busy_next = 1'b1;
            step_next = ST_POS_MUL;
        end
        else if (busy_reg)
        begin
            if (step_reg == ST_DONE)
            begin
                // hold on the last step until the output register frees up
                if (merge_ready)
                    busy_next = 1'b0;
            end
            else
            begin
                step_next = ifs_step_t'(step_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= ST_POS_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctl.load = in_accept;
    assign ctl.run  = busy_reg;
    assign ctl.step = step_reg;

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        ifs_lane #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_lane (
            .clk       (clk),
            .ctl       (ctl),
            .meas_pos  (meas_arr[a]),
            .goal_pos  (goal_arr[a]),
            .goal_vel  (gvel_arr[a]),
            .ext_force (frc_arr[a]),
            .vel_in    (vel_state[a]),
            .stiff     (stiff_reg[a*COEF_BITS +: COEF_BITS]),
            .damp      (damp_reg[a*COEF_BITS +: COEF_BITS]),
            .imass     (imass_reg[a*COEF_BITS +: COEF_BITS]),
            .dt        (dt_reg),
            .pos_out   (lane_pos[a]),
            .vel_out   (lane_vel[a])
        );
    end

    ifs_merge #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .out_stall   (out_stall),
        .lane_pos    (lane_pos),
        .lane_vel    (lane_vel),
        .out_valid   (out_valid),
        .merge_ready (merge_ready),
        .cmd_pos     (cmd_pos),
        .cmd_vel     (cmd_vel),
        .vel_state   (vel_state)
    );

endmodule

// ----- sv/ifs_lane.sv -----
// One axis lane: sequenced Euler step around a single shared multiplier.
module ifs_lane #(
    parameter int DATA_WIDTH = ifs_pkg::DATA_WIDTH_DEF
) (
    input  logic                              clk,
    input  ifs_pkg::ifs_ctl_t                 ctl,
    input  logic signed [DATA_WIDTH-1:0]      meas_pos,
    input  logic signed [DATA_WIDTH-1:0]      goal_pos,
    input  logic signed [DATA_WIDTH-1:0]      goal_vel,
    input  logic signed [DATA_WIDTH-1:0]      ext_force,
    input  logic signed [DATA_WIDTH-1:0]      vel_in,
    input  logic [ifs_pkg::COEF_BITS-1:0]     stiff,
    input  logic [ifs_pkg::COEF_BITS-1:0]     damp,
    input  logic [ifs_pkg::COEF_BITS-1:0]     imass,
    input  logic [ifs_pkg::DT_BITS-1:0]       dt,
    output logic signed [DATA_WIDTH-1:0]      pos_out,
    output logic signed [DATA_WIDTH-1:0]      vel_out
);
    import ifs_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int MA  = (DW + 1 > ACC_SPLIT + 1) ? DW + 1 : ACC_SPLIT + 1;
    localparam int PW  = MA + DT_BITS + 1;
    localparam int AW  = DW + COEF_BITS + KD_SHIFT + 3;
    localparam int AHW = AW - ACC_SPLIT;
    localparam int TW  = AHW + DT_BITS + 1;
    localparam int SW  = TW - VEL_SHIFT + 1;

    logic signed [DW-1:0]  meas_reg;
    logic signed [DW-1:0]  goal_reg;
    logic signed [DW-1:0]  gvel_reg;
    logic signed [DW-1:0]  frc_reg;
    logic signed [PW-1:0]  pr_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [DT_BITS-1:0]    lo_reg;
    logic signed [TW-1:0]  t_reg;
    logic signed [DW-1:0]  pos_reg;

    logic signed [MA-1:0]  op_s;
    logic [DT_BITS-1:0]    op_u;
    logic signed [PW-1:0]  prod;
    logic signed [DW:0]    gp_diff;
    logic signed [DW:0]    gv_diff;
    logic signed [AW-1:0]  pr_acc;
    logic signed [AHW-1:0] acc_hi;
    logic signed [SW-1:0]  pos_sum;
    logic signed [SW-1:0]  vel_sum;

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
        logic [SW-DW:0] top_bits;
        top_bits = x[SW-1:DW-1];
        if ((&top_bits) || !(|top_bits))
            sat_dw = x[DW-1:0];
        else if (x[SW-1])
            sat_dw = {1'b1, {(DW-1){1'b0}}};
        else
            sat_dw = {1'b0, {(DW-1){1'b1}}};
    endfunction

    assign gp_diff = (DW+1)'(goal_reg) - (DW+1)'(meas_reg);
    assign gv_diff = (DW+1)'(gvel_reg) - (DW+1)'(vel_in);
    assign acc_hi  = acc_reg[AW-1:ACC_SPLIT];

    // Operand select for the shared multiplier
    always_comb
    begin
        op_s = '0;
        op_u = '0;
        case (ctl.step)
            ST_POS_MUL:
            begin
                op_s = MA'(vel_in);
                op_u = dt;
            end
            ST_K_MUL:
            begin
                op_s = MA'(gp_diff);
                op_u = DT_BITS'(stiff);
            end
            ST_D_MUL:
            begin
                op_s = MA'(gv_diff);
                op_u = DT_BITS'(damp);
            end
            ST_F_MUL:
            begin
                op_s = MA'(frc_reg);
                op_u = DT_BITS'(imass);
            end
            ST_LO_MUL:
            begin
                op_s = MA'({1'b0, acc_reg[ACC_SPLIT-1:0]});
                op_u = dt;
            end
            ST_HI_MUL:
            begin
                op_s = MA'(acc_hi);
                op_u = dt;
            end
            default:
            begin
                op_s = '0;
                op_u = '0;
            end
        endcase
    end

    assign prod    = op_s * $signed({1'b0, op_u});
    assign pr_acc  = AW'(pr_reg);
    assign pos_sum = SW'(meas_reg) + SW'(pr_reg >>> POS_SHIFT);
    assign vel_sum = SW'(vel_in) + SW'(t_reg >>> VEL_SHIFT);

    assign pos_out = pos_reg;
    assign vel_out = sat_dw(vel_sum);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            meas_reg <= meas_pos;
            goal_reg <= goal_pos;
            gvel_reg <= goal_vel;
            frc_reg  <= ext_force;
        end
        if (ctl.run)
        begin
            case (ctl.step)
                ST_POS_MUL:
                begin
                    pr_reg <= prod;
                end
                ST_K_MUL:
                begin
                    pos_reg <= sat_dw(pos_sum);
                    pr_reg  <= prod;
                end
                ST_D_MUL:
                begin
                    acc_reg <= pr_acc <<< KD_SHIFT;
                    pr_reg  <= prod;
                end
                ST_F_MUL:
                begin
                    acc_reg <= acc_reg + (pr_acc <<< KD_SHIFT);
                    pr_reg  <= prod;
                end
                ST_ACC:
                begin
                    acc_reg <= acc_reg + pr_acc;
                end
                ST_LO_MUL:
                begin
                    pr_reg <= prod;
                end
                ST_HI_MUL:
                begin
                    // keep the carry-in from the low half of dt*acc
                    lo_reg <= pr_reg[ACC_SPLIT+DT_BITS-1:ACC_SPLIT];
                    pr_reg <= prod;
                end
                ST_T_SUM:
                begin
                    t_reg <= TW'(pr_reg) + TW'({1'b0, lo_reg});
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- sv/ifs_merge.sv -----
// Merge stage: gathers lane results into the output register and velocity state.
module ifs_merge #(
    parameter int DATA_WIDTH = ifs_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic                         out_stall,
    input  logic signed [DATA_WIDTH-1:0] lane_pos [ifs_pkg::AXES],
    input  logic signed [DATA_WIDTH-1:0] lane_vel [ifs_pkg::AXES],
    output logic                         out_valid,
    output logic                         merge_ready,
    output logic signed [DATA_WIDTH-1:0] cmd_pos [ifs_pkg::AXES],
    output logic signed [DATA_WIDTH-1:0] cmd_vel [ifs_pkg::AXES],
    output logic signed [DATA_WIDTH-1:0] vel_state [ifs_pkg::AXES]
);
    import ifs_pkg::*;

    logic                         out_valid_reg;
    logic signed [DATA_WIDTH-1:0] cmd_pos_reg   [AXES];
    logic signed [DATA_WIDTH-1:0] cmd_vel_reg   [AXES];
    logic signed [DATA_WIDTH-1:0] vel_state_reg [AXES];

    assign merge_ready = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign cmd_pos     = cmd_pos_reg;
    assign cmd_vel     = cmd_vel_reg;
    assign vel_state   = vel_state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                vel_state_reg[a] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                vel_state_reg <= lane_vel;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cmd_pos_reg <= lane_pos;
            cmd_vel_reg <= lane_vel;
        end
    end

endmodule

// ----- sv/ifs_checker.sv -----
// Port-level checks on the impedance filter step, bound to the top level.
module ifs_checker #(
    parameter int DATA_WIDTH = ifs_pkg::DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [DATA_WIDTH-1:0] cmd_pos_x,
    input logic signed [DATA_WIDTH-1:0] cmd_pos_y,
    input logic signed [DATA_WIDTH-1:0] cmd_pos_z,
    input logic signed [DATA_WIDTH-1:0] cmd_vel_x,
    input logic signed [DATA_WIDTH-1:0] cmd_vel_y,
    input logic signed [DATA_WIDTH-1:0] cmd_vel_z
);
    import ifs_pkg::*;

    // An accepted beat still has the input side stalled at the final step
    a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##BUSY_CYCLES in_stall)
        else $error("input side released before the step sequence finished");

    // The sequencer only goes idle by handing a result to the output register
    a_release_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("sequencer went idle without a result");

    // A fresh result comes only from a beat that was being worked on
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no beat in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(cmd_pos_x) && $stable(cmd_pos_y)
            && $stable(cmd_pos_z) && $stable(cmd_vel_x) && $stable(cmd_vel_y)
            && $stable(cmd_vel_z)))
        else $error("stalled output beat changed");

endmodule

bind impedance_filter_step ifs_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ifs_checker (.*);
